### hw/rtl/alpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpd_pkg: shared types and constants for the length-prefixed deframer
// Register indexes, config and result records, ASCII codes and widths.
// ----------------------------------------------------------------------------
package alpd_pkg;

    // Field and counter widths
    localparam int BYTE_W     = 8;
    localparam int HDR_W      = 16;
    localparam int OFS_W      = 16;
    localparam int DIG_W      = 4;
    localparam int ACC_W      = 34;
    localparam int SEEN_W     = 36;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_W    = 48;
    localparam int TUSER_W    = 2;

    // Length field can never be wider than this
    localparam logic [DIG_W-1:0] MAX_LENGTH_DIGITS = 4'd10;

    // Default width of the header length register
    localparam int HEADER_COUNT_BITS_DEF = 16;

    // Register reset values
    localparam logic [HDR_W-1:0] HDR_LEN_RST    = 16'd8;
    localparam logic [OFS_W-1:0] LEN_OFS_RST    = 16'd1;
    localparam logic [DIG_W-1:0] LEN_DIGITS_RST = 4'd8;
    localparam logic             LEN_MODE_RST   = 1'b0;

    // Byte counter ceiling
    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

    // ASCII codes
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_LEN    = 8'd0,
        REG_LENGTH_OFFSET = 8'd1,
        REG_LENGTH_DIGITS = 8'd2,
        REG_LENGTH_MODE   = 8'd3
    } reg_idx_t;

    // Frame phase
    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } phase_t;

    // Current register values
    typedef struct packed {
        logic [HDR_W-1:0] header_len;
        logic [OFS_W-1:0] length_offset;
        logic [DIG_W-1:0] length_digits;
        logic             length_mode;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic [ACC_W-1:0]  frame_length;
        logic              frame_error;
        logic              frame_done;
        logic              in_body;
        logic [BYTE_W-1:0] byte_out;
    } result_t;

    // Decimal digit test
    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // Whitespace as skipped before the first digit
    function automatic logic is_blank(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage : alpd_pkg
`default_nettype wire

### hw/rtl/alpd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpd_cfg: configuration registers
// Decodes the write channel and holds the four framing registers.
// ----------------------------------------------------------------------------
module alpd_cfg #(
    parameter int HEADER_COUNT_BITS = alpd_pkg::HEADER_COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [alpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [alpd_pkg::CFG_DATA_W-1:0] cfg_data,
    output alpd_pkg::cfg_t                       cfg
);
    import alpd_pkg::*;

    // Header length register keeps at most HEADER_COUNT_BITS bits
    localparam int HLEN_W = (HEADER_COUNT_BITS < HDR_W) ? HEADER_COUNT_BITS : HDR_W;

    logic [HLEN_W-1:0] header_len_reg;
    logic [OFS_W-1:0]  length_offset_reg;
    logic [DIG_W-1:0]  length_digits_reg;
    logic              length_mode_reg;
    logic              wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_len_reg    <= HLEN_W'(HDR_LEN_RST);
            length_offset_reg <= LEN_OFS_RST;
            length_digits_reg <= LEN_DIGITS_RST;
            length_mode_reg   <= LEN_MODE_RST;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                REG_HEADER_LEN:    header_len_reg    <= cfg_data[HLEN_W-1:0];
                REG_LENGTH_OFFSET: length_offset_reg <= cfg_data[OFS_W-1:0];
                REG_LENGTH_DIGITS: length_digits_reg <= cfg_data[DIG_W-1:0];
                REG_LENGTH_MODE:   length_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Present the register set
    always_comb
    begin
        cfg.header_len    = HDR_W'(header_len_reg);
        cfg.length_offset = length_offset_reg;
        cfg.length_digits = length_digits_reg;
        cfg.length_mode   = length_mode_reg;
    end

endmodule : alpd_cfg
`default_nettype wire

### hw/rtl/alpd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpd_core: frame tracker and length decoder
// Counts bytes, decodes the ASCII length field and flags frame end or error.
// ----------------------------------------------------------------------------
module alpd_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire alpd_pkg::cfg_t              cfg,
    input  wire logic                        in_fire,
    input  wire logic [alpd_pkg::BYTE_W-1:0] in_byte,
    output alpd_pkg::result_t                res
);
    import alpd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              stopped_reg, stopped_next;
    logic              started_reg, started_next;

    logic [HDR_W-1:0]  hlen;
    logic [DIG_W-1:0]  nd;
    logic [SEEN_W-1:0] seen_inc;
    logic [OFS_W:0]    win_end;
    logic              in_win;
    logic              take;
    logic              ch_digit;
    logic [ACC_W-1:0]  acc_x10;
    logic [ACC_W-1:0]  acc_new;
    logic              stopped_new;
    logic              started_new;
    logic              header_end;
    logic              check;
    logic signed [SEEN_W:0] diff_m0;
    logic signed [SEEN_W:0] acc_ext;
    logic              eq_hit;
    logic              gt_hit;
    logic              done;
    logic              err;

    // Effective register values
    assign hlen = (cfg.header_len == '0) ? HDR_W'(1) : cfg.header_len;
    assign nd   = (cfg.length_digits > MAX_LENGTH_DIGITS) ? MAX_LENGTH_DIGITS
                                                          : cfg.length_digits;

    // Saturating byte count including this byte
    assign seen_inc = (seen_reg != SEEN_MAX) ? seen_reg + SEEN_W'(1) : seen_reg;

    // Is this byte inside the length field
    assign win_end = {1'b0, cfg.length_offset} + (OFS_W+1)'(nd);
    assign in_win  = (phase_reg == PH_HEADER)
                   && (seen_inc >= SEEN_W'(cfg.length_offset))
                   && (seen_inc < SEEN_W'(win_end));
    assign take    = in_win && !stopped_reg;

    // Digit accumulate: acc*10 + digit, kept to ACC_W bits
    assign ch_digit = is_digit(in_byte);
    assign acc_x10  = {acc_reg[ACC_W-4:0], 3'b000} + {acc_reg[ACC_W-2:0], 1'b0};

    always_comb
    begin
        acc_new     = acc_reg;
        stopped_new = stopped_reg;
        started_new = started_reg;
        if (take)
        begin
            if (ch_digit)
            begin
                acc_new     = acc_x10 + ACC_W'(in_byte[3:0]);
                started_new = 1'b1;
            end
            else if (!(!started_reg && is_blank(in_byte)))
            begin
                stopped_new = 1'b1;
            end
        end
    end

    // Header end and completion check
    assign header_end = (phase_reg == PH_HEADER) && (seen_inc >= SEEN_W'(hlen));
    assign check      = header_end || (phase_reg == PH_BODY);

    // Mode 0 compares seen - hlen against the length, mode 1 seen directly
    assign diff_m0 = $signed({1'b0, seen_inc}) - $signed((SEEN_W+1)'(hlen));
    assign acc_ext = $signed((SEEN_W+1)'(acc_new));

    always_comb
    begin
        if (cfg.length_mode)
        begin
            eq_hit = (seen_inc == SEEN_W'(acc_new));
            gt_hit = (seen_inc > SEEN_W'(acc_new));
        end
        else
        begin
            eq_hit = (diff_m0 == acc_ext);
            gt_hit = (diff_m0 > acc_ext);
        end
    end

    assign done = check && eq_hit;
    assign err  = check && gt_hit;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (done || err)
            phase_next = PH_HEADER;
        else if (header_end)
            phase_next = PH_BODY;
    end

    // Next counters and decoder flags; rearm on frame end
    always_comb
    begin
        if (done || err)
        begin
            seen_next    = '0;
            acc_next     = '0;
            stopped_next = 1'b0;
            started_next = 1'b0;
        end
        else
        begin
            seen_next    = seen_inc;
            acc_next     = acc_new;
            stopped_next = stopped_new;
            started_next = started_new;
        end
    end

    // State registers advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            seen_reg    <= '0;
            acc_reg     <= '0;
            stopped_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            seen_reg    <= seen_next;
            acc_reg     <= acc_next;
            stopped_reg <= stopped_next;
            started_reg <= started_next;
        end
    end

    // Result word for this byte
    always_comb
    begin
        res.byte_out     = in_byte;
        res.in_body      = (phase_reg == PH_BODY);
        res.frame_done   = done;
        res.frame_error  = err && !done;
        res.frame_length = check ? acc_new : '0;
    end

endmodule : alpd_core
`default_nettype wire

### hw/rtl/alpd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpd_out_buf: two-entry result buffer
// Registers result words; ready stays high while one word waits downstream.
// ----------------------------------------------------------------------------
module alpd_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire alpd_pkg::result_t push_data,
    output logic                   not_full,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output alpd_pkg::result_t      out_data
);
    import alpd_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign not_full  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule : alpd_out_buf
`default_nettype wire

### hw/rtl/ascii_length_prefixed_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Each byte's result word is registered in the result buffer as it is taken.
// Throughput: one byte per cycle while the result buffer has room; the
// per-byte decode (multiply by ten, add, compare against the byte count) sits
// between the frame state and the two-entry result buffer.
// Reset: rst_n clears the frame state and the result buffer and loads the
// register defaults (header 8, offset 1, digits 8, body-length mode).
// ----------------------------------------------------------------------------
// ascii_length_prefixed_deframer_top: length-prefixed response deframer
// Tags each byte as header or body, decodes the ASCII length and marks the
// word that completes a frame or the header end that overruns it.
// ----------------------------------------------------------------------------
module ascii_length_prefixed_deframer_top #(
    parameter int HEADER_COUNT_BITS = alpd_pkg::HEADER_COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input byte stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [alpd_pkg::TDATA_IN_W-1:0] s_tdata,  // [7:0] byte_value
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [alpd_pkg::TDATA_W-1:0]         m_tdata,  // [7:0] byte_out,
                                                           // [41:8] frame_length
    output logic [alpd_pkg::TUSER_W-1:0]         m_tuser,  // [0] in_body,
                                                           // [1] frame_error
    output logic                                 m_tlast,  // frame_done
    // Configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [alpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [alpd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import alpd_pkg::*;

    cfg_t    cfg;
    result_t core_res;
    result_t out_res;
    logic    buf_not_full;
    logic    in_fire;

    assign s_tready = buf_not_full;
    assign in_fire  = s_tvalid && s_tready;

    // Register file
    alpd_cfg #(
        .HEADER_COUNT_BITS (HEADER_COUNT_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame tracking and length decode
    alpd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_fire (in_fire),
        .in_byte (s_tdata[BYTE_W-1:0]),
        .res     (core_res)
    );

    // Result register with skid entry
    alpd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (core_res),
        .not_full  (buf_not_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result word
    always_comb
    begin
        m_tdata = {{(TDATA_W-ACC_W-BYTE_W){1'b0}}, out_res.frame_length, out_res.byte_out};
        m_tuser = {out_res.frame_error, out_res.in_body};
        m_tlast = out_res.frame_done;
    end

endmodule : ascii_length_prefixed_deframer_top
`default_nettype wire
